// File: rtl/core/generational_context_buffer_table_macros.svh
// Assertion macros for the handle table block.
`ifndef GENERATIONAL_CONTEXT_BUFFER_TABLE_MACROS_SVH
`define GENERATIONAL_CONTEXT_BUFFER_TABLE_MACROS_SVH
`ifndef SYNTH
`define GCBT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define GCBT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define GCBT_ASSERT_IMP(label, clk, rst_n, a, c)
`define GCBT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/gcbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gcbt_pkg
// Shared types and constants of the context and buffer handle table.
// ---------------------------------------------------------------------------
package gcbt_pkg;
    localparam int CONTEXT_SLOTS_DEF = 16;
    localparam int BUFFER_SLOTS_DEF  = 64;
    localparam int MAX_BATCH_DEF     = 64;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_ALLOC   = 3'd1;
    localparam logic [2:0] CMD_FREE    = 3'd2;
    localparam logic [2:0] CMD_SUBMIT  = 3'd3;
    localparam logic [2:0] CMD_SETSTATE = 3'd4;
    localparam logic [2:0] CMD_DESTROY = 3'd5;

    localparam logic [0:0] REG_BUDGET = 1'b0;
    localparam logic [0:0] REG_LIMIT  = 1'b1;

    localparam logic [31:0] GEN_EXHAUSTED = 32'hffff_ffff;
    localparam logic [39:0] PAGE_BYTES    = 40'd4096;
    localparam logic [31:0] BUDGET_RESET  = 32'd134217728;
    localparam logic [31:0] LIMIT_RESET   = 32'd67108864;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [47:0] handle;
        logic [63:0] owner_task;
        logic [63:0] device_number;
        logic [39:0] buffer_bytes;
        logic [2:0]  buffer_kind;
        logic [6:0]  batch_count;
        logic        batch_all_valid;
        logic [2:0]  new_run_state;
        logic        page_available;
    } req_t;

    typedef struct packed {
        logic        failed;
        logic [47:0] issued_handle;
        logic        wake_waiters;
    } rsp_t;

    // scan request from sequencer to slot scanner
    typedef struct packed {
        logic start;
        logic [31:0] gen_excl;
    } scan_ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/gcbt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gcbt_req_if / gcbt_rsp_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface gcbt_req_if;
    logic valid;
    logic ready;
    gcbt_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gcbt_rsp_if;
    logic valid;
    logic ready;
    gcbt_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/generational_context_buffer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// generational_context_buffer_table
// Context and buffer slot tables addressed by generation-checked handles.
// ---------------------------------------------------------------------------
// One request is taken at a time. Create scans the context slots and alloc
// the buffer slots one slot a cycle, through a single shared comparator; the
// result is held in an output register and the next request is taken once it
// has transferred. Buffer generations sit in a store that is read through
// registers; after reset a clearing pass zeroes it, during which the request
// side is not ready.
module generational_context_buffer_table #(
    parameter int CONTEXT_SLOTS = gcbt_pkg::CONTEXT_SLOTS_DEF,
    parameter int BUFFER_SLOTS  = gcbt_pkg::BUFFER_SLOTS_DEF,
    parameter int MAX_BATCH     = gcbt_pkg::MAX_BATCH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gcbt_req_if.sink   req,
    gcbt_rsp_if.source rsp,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import gcbt_pkg::*;
`include "generational_context_buffer_table_macros.svh"

    localparam int CW = (CONTEXT_SLOTS > 1) ? $clog2(CONTEXT_SLOTS) : 1;
    localparam int BW = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int SW = (CONTEXT_SLOTS > BUFFER_SLOTS) ? CW : BW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DO   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;

    // configuration
    logic [31:0] budget_reg, limit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BUDGET) budget_reg <= cfg_wdata;
            else limit_reg <= cfg_wdata;
        end
    end

    // slot state
    logic [CONTEXT_SLOTS-1:0] ctx_used_reg;
    logic [31:0] ctx_gen_reg [CONTEXT_SLOTS];
    logic [2:0]  ctx_state_reg [CONTEXT_SLOTS];
    logic [63:0] ctx_owner_mem [CONTEXT_SLOTS];
    logic [63:0] ctx_dev_mem [CONTEXT_SLOTS];
    logic [63:0] ctx_sub_mem [CONTEXT_SLOTS];
    logic [63:0] ctx_cmp_mem [CONTEXT_SLOTS];
    logic [39:0] ctx_bytes_mem [CONTEXT_SLOTS];
    logic [31:0] ctx_budget_mem [CONTEXT_SLOTS];
    logic [BUFFER_SLOTS-1:0] buf_used_reg;
    logic [31:0] buf_gen_mem [BUFFER_SLOTS];
    logic [2:0]  buf_kind_mem [BUFFER_SLOTS];
    logic [39:0] buf_bytes_mem [BUFFER_SLOTS];
    logic [63:0] buf_owner_mem [BUFFER_SLOTS];

    logic [2:0]  state_reg;
    req_t        q_reg;
    rsp_t        out_reg;
    logic [SW:0] idx_reg;
    logic [CW-1:0] ctx_sel_reg;
    logic        lk_ok_reg;
    logic [39:0] used_rd_reg;
    logic [31:0] bud_rd_reg;
    logic [63:0] sub_rd_reg, cmp_rd_reg;
    logic [31:0] bgen_lk_reg, bgen_sc_reg;

    // handle decode, shared by both tables
    logic [15:0] h_slot;
    logic [31:0] h_gen;
    logic        is_buf;
    assign h_slot = q_reg.handle[15:0];
    assign h_gen  = q_reg.handle[47:16];
    assign is_buf = (q_reg.cmd == CMD_FREE);

    logic [15:0] h_idx;
    assign h_idx = h_slot - 16'd1;

    // shared scan comparator: one slot a cycle
    logic [31:0] sc_gen;
    logic        sc_used, sc_hit, sc_last;
    logic [CW-1:0] sc_ci;
    logic [BW-1:0] sc_bi;
    assign sc_ci = idx_reg[CW-1:0];
    assign sc_bi = idx_reg[BW-1:0];
    always_comb
    begin
        if (q_reg.cmd == CMD_CREATE)
        begin
            sc_gen  = ctx_gen_reg[sc_ci];
            sc_used = ctx_used_reg[sc_ci];
            sc_last = (idx_reg == (SW+1)'(CONTEXT_SLOTS - 1));
        end
        else
        begin
            sc_gen  = bgen_sc_reg;
            sc_used = buf_used_reg[sc_bi];
            sc_last = (idx_reg == (SW+1)'(BUFFER_SLOTS - 1));
        end
        sc_hit = !sc_used && (sc_gen != GEN_EXHAUSTED);
    end

    logic [40:0] sum_bytes;
    assign sum_bytes = {1'b0, used_rd_reg} + {1'b0, q_reg.buffer_bytes};
    logic [31:0] new_gen;
    assign new_gen = sc_gen + 32'd1;

    // buffer generation store: lookup read at the accepting edge, scan read
    // one slot ahead of the sequencer
    logic [BW-1:0] lk_addr, sc_addr;
    logic          bg_we;
    logic [31:0]   bg_wdata;
    assign lk_addr  = req.data.handle[BW-1:0] - BW'(1);
    assign bg_we    = (state_reg == S_CLR) ||
                      (state_reg == S_SCAN && sc_hit && q_reg.cmd != CMD_CREATE);
    assign bg_wdata = (state_reg == S_CLR) ? 32'd0 : new_gen;
    always_comb
    begin
        if (state_reg == S_IDLE)
            sc_addr = '0;
        else if (state_reg == S_SCAN && !sc_hit && !sc_last)
            sc_addr = sc_bi + BW'(1);
        else
            sc_addr = sc_bi;
    end

    always_ff @(posedge clk)
    begin
        if (bg_we) buf_gen_mem[sc_bi] <= bg_wdata;
        bgen_lk_reg <= buf_gen_mem[lk_addr];
        bgen_sc_reg <= buf_gen_mem[sc_addr];
    end

    // lookup check
    logic lk_ok;
    always_comb
    begin
        if (is_buf)
            lk_ok = (h_slot != 16'd0) && (32'(h_slot) <= 32'(BUFFER_SLOTS)) &&
                    (h_gen != 32'd0) && buf_used_reg[h_idx[BW-1:0]] &&
                    (bgen_lk_reg == h_gen);
        else
            lk_ok = (h_slot != 16'd0) && (32'(h_slot) <= 32'(CONTEXT_SLOTS)) &&
                    (h_gen != 32'd0) && ctx_used_reg[h_idx[CW-1:0]] &&
                    (ctx_gen_reg[h_idx[CW-1:0]] == h_gen);
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = out_reg;

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            idx_reg      <= '0;
            ctx_used_reg <= '0;
            buf_used_reg <= '0;
            for (int i = 0; i < CONTEXT_SLOTS; i++)
            begin
                ctx_gen_reg[i]   <= '0;
                ctx_state_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                    if (idx_reg == (SW+1)'(BUFFER_SLOTS - 1))
                        state_reg <= S_IDLE;
                    else
                        idx_reg <= idx_reg + (SW+1)'(1);
                S_IDLE:
                    if (req.valid)
                    begin
                        q_reg     <= req.data;
                        idx_reg   <= '0;
                        out_reg   <= '{failed: 1'b1, issued_handle: '0, wake_waiters: 1'b0};
                        state_reg <= S_LOOK;
                    end
                S_LOOK:
                begin
                    lk_ok_reg   <= lk_ok;
                    ctx_sel_reg <= h_idx[CW-1:0];
                    used_rd_reg <= ctx_bytes_mem[h_idx[CW-1:0]];
                    bud_rd_reg  <= ctx_budget_mem[h_idx[CW-1:0]];
                    sub_rd_reg  <= ctx_sub_mem[h_idx[CW-1:0]];
                    cmp_rd_reg  <= ctx_cmp_mem[h_idx[CW-1:0]];
                    priority if (q_reg.cmd == CMD_CREATE)
                        state_reg <= (q_reg.owner_task != 64'd0) ? S_SCAN : S_OUT;
                    else if (q_reg.cmd == CMD_ALLOC)
                        state_reg <= (q_reg.buffer_bytes != 40'd0 &&
                            q_reg.buffer_bytes <= {8'd0, limit_reg} && lk_ok) ? S_DO : S_OUT;
                    else if (q_reg.cmd == CMD_FREE && lk_ok)
                    begin
                        buf_used_reg[h_idx[BW-1:0]] <= 1'b0;
                        out_reg.failed <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (q_reg.cmd == CMD_SUBMIT)
                        state_reg <= (q_reg.batch_count != 7'd0 &&
                            32'(q_reg.batch_count) <= 32'(MAX_BATCH) && lk_ok &&
                            q_reg.batch_all_valid) ? S_DO : S_OUT;
                    else if (q_reg.cmd == CMD_SETSTATE && lk_ok)
                    begin
                        ctx_state_reg[h_idx[CW-1:0]] <= q_reg.new_run_state;
                        out_reg.failed <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (q_reg.cmd == CMD_DESTROY && lk_ok)
                    begin
                        ctx_used_reg[h_idx[CW-1:0]]  <= 1'b0;
                        ctx_state_reg[h_idx[CW-1:0]] <= '0;
                        out_reg.failed       <= 1'b0;
                        out_reg.wake_waiters <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_DO:
                    if (q_reg.cmd == CMD_SUBMIT)
                    begin
                        ctx_sub_mem[ctx_sel_reg] <= sub_rd_reg + 64'(q_reg.batch_count);
                        ctx_cmp_mem[ctx_sel_reg] <= cmp_rd_reg + 64'(q_reg.batch_count);
                        out_reg.failed       <= 1'b0;
                        out_reg.wake_waiters <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= (sum_bytes <= {9'd0, bud_rd_reg}) ? S_SCAN : S_OUT;
                S_SCAN:
                    if (sc_hit)
                    begin
                        state_reg <= S_OUT;
                        if (q_reg.cmd == CMD_CREATE)
                        begin
                            ctx_gen_reg[sc_ci]    <= new_gen;
                            ctx_used_reg[sc_ci]   <= 1'b1;
                            ctx_state_reg[sc_ci]  <= 3'd1;
                            ctx_owner_mem[sc_ci]  <= q_reg.owner_task;
                            ctx_dev_mem[sc_ci]    <= q_reg.device_number;
                            ctx_sub_mem[sc_ci]    <= '0;
                            ctx_cmp_mem[sc_ci]    <= '0;
                            ctx_bytes_mem[sc_ci]  <= '0;
                            ctx_budget_mem[sc_ci] <= budget_reg;
                            out_reg.failed        <= 1'b0;
                            out_reg.issued_handle <= {new_gen, 16'(sc_ci) + 16'd1};
                        end
                        else
                        begin
                            // generation bump goes through the store write port
                            if (q_reg.buffer_bytes <= PAGE_BYTES && q_reg.page_available)
                            begin
                                buf_used_reg[sc_bi]  <= 1'b1;
                                buf_kind_mem[sc_bi]  <= q_reg.buffer_kind;
                                buf_bytes_mem[sc_bi] <= q_reg.buffer_bytes;
                                buf_owner_mem[sc_bi] <= q_reg.owner_task;
                                ctx_bytes_mem[ctx_sel_reg] <= sum_bytes[39:0];
                                out_reg.failed        <= 1'b0;
                                out_reg.issued_handle <= {new_gen, 16'(sc_bi) + 16'd1};
                            end
                        end
                    end
                    else if (sc_last)
                        state_reg <= S_OUT;
                    else
                        idx_reg <= idx_reg + (SW+1)'(1);
                S_OUT:
                    if (rsp.ready) state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `GCBT_ASSERT_IMP(a_ready_idle, clk, rst_n, req.ready, !rsp.valid)
    `GCBT_ASSERT_NEXT(a_take_look, clk, rst_n, req.valid && req.ready, state_reg == S_LOOK)
    `GCBT_ASSERT_NEXT(a_out_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
    `GCBT_ASSERT_IMP(a_handle_fail, clk, rst_n, rsp.valid && rsp.data.failed,
        rsp.data.issued_handle == 48'd0 && !rsp.data.wake_waiters)
endmodule
`default_nettype wire

// File: tb/sv/generational_context_buffer_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// generational_context_buffer_table_tb
// Drives random and directed table requests through the request channel,
// predicts each result from a private copy of the slot tables and checks
// every result transfer in order, across several register settings.
// ---------------------------------------------------------------------------
module generational_context_buffer_table_tb;
    import gcbt_pkg::*;

    localparam int NCTX      = CONTEXT_SLOTS_DEF;
    localparam int NBUF      = BUFFER_SLOTS_DEF;
    localparam int BATCH_MAX = MAX_BATCH_DEF;
    localparam int LIMIT     = 400000;

    // Handle table prediction and result checking
    class handle_table_board;
        bit          ctx_live [NCTX];
        logic [31:0] ctx_gen [NCTX];
        logic [39:0] ctx_used [NCTX];
        logic [31:0] ctx_budget [NCTX];
        bit          buf_live [NBUF];
        logic [31:0] buf_gen [NBUF];
        logic [31:0] budget_reg;
        logic [31:0] limit_reg;
        rsp_t        awaited [$];
        int          errors;

        function new();
            budget_reg = BUDGET_RESET;
            limit_reg  = LIMIT_RESET;
            errors     = 0;
            foreach (ctx_live[i])
            begin
                ctx_live[i] = 0;
                ctx_gen[i]  = '0;
            end
            foreach (buf_live[i])
            begin
                buf_live[i] = 0;
                buf_gen[i]  = '0;
            end
        endfunction

        function int find_ctx(logic [47:0] h);
            int s;
            s = int'(h[15:0]);
            if (s == 0 || s > NCTX || h[47:16] == 0) return -1;
            if (!ctx_live[s-1] || ctx_gen[s-1] != h[47:16]) return -1;
            return s - 1;
        endfunction

        function int find_buf(logic [47:0] h);
            int s;
            s = int'(h[15:0]);
            if (s == 0 || s > NBUF || h[47:16] == 0) return -1;
            if (!buf_live[s-1] || buf_gen[s-1] != h[47:16]) return -1;
            return s - 1;
        endfunction

        // work out the result of one accepted request and update the tables
        function void note_request(req_t r);
            rsp_t e;
            int   c;
            e = '{failed: 1'b1, issued_handle: '0, wake_waiters: 1'b0};
            case (r.cmd)
                CMD_CREATE:
                    if (r.owner_task != 0)
                    begin
                        for (int i = 0; i < NCTX; i++)
                        begin
                            if (ctx_live[i] || ctx_gen[i] == GEN_EXHAUSTED) continue;
                            ctx_gen[i]    = ctx_gen[i] + 32'd1;
                            ctx_live[i]   = 1;
                            ctx_used[i]   = '0;
                            ctx_budget[i] = budget_reg;
                            e.issued_handle = {ctx_gen[i], 16'(i + 1)};
                            e.failed = 1'b0;
                            break;
                        end
                    end
                CMD_ALLOC:
                    if (r.buffer_bytes != 0 && r.buffer_bytes <= {8'd0, limit_reg})
                    begin
                        c = find_ctx(r.handle);
                        if (c >= 0 && ({1'b0, ctx_used[c]} + {1'b0, r.buffer_bytes})
                                      <= {9'd0, ctx_budget[c]})
                        begin
                            for (int i = 0; i < NBUF; i++)
                            begin
                                if (buf_live[i] || buf_gen[i] == GEN_EXHAUSTED) continue;
                                // generation moves even when the page check fails
                                buf_gen[i] = buf_gen[i] + 32'd1;
                                if (r.buffer_bytes > PAGE_BYTES || !r.page_available) break;
                                buf_live[i] = 1;
                                ctx_used[c] = ctx_used[c] + r.buffer_bytes;
                                e.issued_handle = {buf_gen[i], 16'(i + 1)};
                                e.failed = 1'b0;
                                break;
                            end
                        end
                    end
                CMD_FREE:
                begin
                    c = find_buf(r.handle);
                    if (c >= 0)
                    begin
                        buf_live[c] = 0;
                        e.failed = 1'b0;
                    end
                end
                CMD_SUBMIT:
                    if (r.batch_count != 0 && r.batch_count <= BATCH_MAX)
                    begin
                        c = find_ctx(r.handle);
                        if (c >= 0 && r.batch_all_valid)
                        begin
                            e.wake_waiters = 1'b1;
                            e.failed = 1'b0;
                        end
                    end
                CMD_SETSTATE:
                    if (find_ctx(r.handle) >= 0) e.failed = 1'b0;
                CMD_DESTROY:
                begin
                    c = find_ctx(r.handle);
                    if (c >= 0)
                    begin
                        ctx_live[c] = 0;
                        e.wake_waiters = 1'b1;
                        e.failed = 1'b0;
                    end
                end
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected transfer", 64'(got), 64'd0);
                return;
            end
            want = awaited.pop_front();
            if (got.failed !== want.failed)
                report("failed", 64'(got.failed), 64'(want.failed));
            if (got.issued_handle !== want.issued_handle)
                report("issued_handle", 64'(got.issued_handle), 64'(want.issued_handle));
            if (got.wake_waiters !== want.wake_waiters)
                report("wake_waiters", 64'(got.wake_waiters), 64'(want.wake_waiters));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_BUDGET;
    logic [31:0] cfg_wdata = '0;
    bit          calm = 0;
    bit          hold_req = 0;
    int          cycles = 0;
    handle_table_board board;

    gcbt_req_if req ();
    gcbt_rsp_if rsp ();

    generational_context_buffer_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("generational_context_buffer_table test failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 0;
                rsp.ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            rsp.ready = calm || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready) board.check_result(rsp.data);

    task send(req_t r);
        if (!calm && $urandom_range(99) < 16)
        begin
            repeat ($urandom_range(1, 6))
            begin
                @(negedge clk);
                req.valid = 1'b0;
            end
        end
        @(negedge clk);
        req.valid = 1'b1;
        req.data  = r;
        do @(posedge clk); while (!req.ready);
        board.note_request(r);
    endtask

    task write_reg(logic [0:0] idx, logic [31:0] val);
        @(negedge clk);
        req.valid = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_BUDGET) board.budget_reg = val;
        else board.limit_reg = val;
    endtask

    task drain();
        @(negedge clk);
        req.valid = 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function req_t noise_req();
        req_t r;
        r.cmd             = 3'($urandom_range(7));
        r.handle          = 48'({$urandom, $urandom});
        r.owner_task      = {$urandom, $urandom};
        r.device_number   = {$urandom, $urandom};
        r.buffer_bytes    = 40'({$urandom, $urandom});
        r.buffer_kind     = 3'($urandom_range(7));
        r.batch_count     = 7'($urandom_range(127));
        r.batch_all_valid = 1'($urandom_range(1));
        r.new_run_state   = 3'($urandom_range(7));
        r.page_available  = 1'($urandom_range(1));
        return r;
    endfunction

    // mostly live handles, some stale or malformed
    function logic [47:0] pick_ctx();
        int k;
        k = $urandom_range(99);
        for (int n = 0; n < NCTX && k < 80; n++)
        begin
            int s;
            s = $urandom_range(NCTX - 1);
            if (board.ctx_live[s]) return {board.ctx_gen[s], 16'(s + 1)};
        end
        k = $urandom_range(NCTX - 1);
        case ($urandom_range(3))
            0: return {board.ctx_gen[k] - 32'd1, 16'(k + 1)};
            1: return {board.ctx_gen[k], 16'(k + 1)};
            2: return {32'd1, 16'($urandom_range(NCTX + 1, 65535))};
            default: return {$urandom, 16'($urandom_range(1))};
        endcase
    endfunction

    function logic [47:0] pick_buf();
        int k;
        for (int n = 0; n < NBUF && $urandom_range(99) < 85; n++)
        begin
            int s;
            s = $urandom_range(NBUF - 1);
            if (board.buf_live[s]) return {board.buf_gen[s], 16'(s + 1)};
        end
        k = $urandom_range(NBUF - 1);
        return $urandom_range(1) ? {board.buf_gen[k], 16'(k + 1)} : 48'({$urandom, $urandom});
    endfunction

    function req_t random_req();
        req_t r;
        int   w;
        r = noise_req();
        w = $urandom_range(99);
        if (w < 14)      r.cmd = CMD_CREATE;
        else if (w < 48) r.cmd = CMD_ALLOC;
        else if (w < 68) r.cmd = CMD_FREE;
        else if (w < 80) r.cmd = CMD_SUBMIT;
        else if (w < 89) r.cmd = CMD_SETSTATE;
        else if (w < 96) r.cmd = CMD_DESTROY;
        if (r.cmd == CMD_CREATE && $urandom_range(9) == 0) r.owner_task = '0;
        if (r.cmd == CMD_FREE) r.handle = pick_buf();
        else if (r.cmd <= CMD_DESTROY && r.cmd != CMD_CREATE) r.handle = pick_ctx();
        if (r.cmd == CMD_ALLOC)
        begin
            w = $urandom_range(99);
            r.page_available = ($urandom_range(9) != 0);
            if (w < 65)      r.buffer_bytes = 40'($urandom_range(1, 4096));
            else if (w < 78) r.buffer_bytes = 40'($urandom_range(4097, 70000));
            else if (w < 86) r.buffer_bytes = '0;
            else if (w < 93) r.buffer_bytes = {8'd0, $urandom};
        end
        if (r.cmd == CMD_SUBMIT)
        begin
            r.batch_all_valid = ($urandom_range(4) != 0);
            if ($urandom_range(3) != 0) r.batch_count = 7'($urandom_range(1, BATCH_MAX));
        end
        return r;
    endfunction

    task run_random(int n, bit with_hold);
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == n / 2) hold_req = 1;
            send(random_req());
        end
    endtask

    // directed corner cases
    task run_directed();
        req_t r;
        logic [47:0] ch;
        logic [47:0] bh;
        r = noise_req();
        r.cmd = CMD_CREATE; r.owner_task = '0;                          send(r);
        r.owner_task = '1; r.device_number = '1;                        send(r);
        ch = {32'd1, 16'd1};
        r.owner_task = 64'd5; r.device_number = '0;                     send(r);
        r.cmd = CMD_ALLOC; r.handle = ch; r.page_available = 1'b1;
        r.buffer_bytes = '0;                                             send(r);
        r.buffer_bytes = 40'd4096; r.buffer_kind = 3'd7;                 send(r);
        bh = {32'd1, 16'd1};
        r.buffer_bytes = 40'd4097;                                       send(r);
        r.buffer_bytes = 40'd1; r.page_available = 1'b0;                 send(r);
        r.buffer_bytes = '1; r.page_available = 1'b1;                    send(r);
        r.buffer_bytes = 40'd8; r.handle = {32'd1, 16'd0};               send(r);
        r.handle = {32'd1, 16'd17};                                      send(r);
        r.handle = {32'd0, 16'd1};                                       send(r);
        r.handle = {32'd2, 16'd1};                                       send(r);
        r.cmd = CMD_FREE; r.handle = bh;                                 send(r);
        send(r);
        r.cmd = CMD_SUBMIT; r.handle = ch; r.batch_all_valid = 1'b1;
        r.batch_count = 7'd0;                                            send(r);
        r.batch_count = 7'd65;                                           send(r);
        r.batch_count = 7'd127;                                          send(r);
        r.batch_count = 7'd64;                                           send(r);
        r.batch_count = 7'd1; r.batch_all_valid = 1'b0;                  send(r);
        r.cmd = CMD_SETSTATE; r.new_run_state = 3'd7;                    send(r);
        r.cmd = CMD_DESTROY;                                             send(r);
        send(r);
        r.cmd = 3'd6;                                                    send(r);
        r.cmd = 3'd7;                                                    send(r);
    endtask

    initial
    begin
        board     = new();
        req.valid = 1'b0;
        req.data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        calm = 1;
        run_random(120, 0);
        calm = 0;
        drain();

        write_reg(REG_BUDGET, 32'd20000);
        write_reg(REG_LIMIT, 32'd5000);
        run_random(200, 1);
        drain();

        write_reg(REG_BUDGET, 32'd0);
        write_reg(REG_LIMIT, 32'd1);
        run_random(60, 0);
        drain();

        write_reg(REG_BUDGET, 32'hffff_ffff);
        write_reg(REG_LIMIT, 32'hffff_ffff);
        run_random(250, 0);
        drain();

        if (board.errors == 0)
            $display("generational_context_buffer_table test passed");
        else
            $display("generational_context_buffer_table test failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/gcbt_pkg.sv
rtl/core/gcbt_if.sv
rtl/core/generational_context_buffer_table.sv
tb/sv/generational_context_buffer_table_tb.sv
